@@ src/pnv_pkg.sv @@
`timescale 1ns / 1ps

package pnv_pkg;

  // Register reset value and counter limit
  localparam logic [15:0] MaxLenReset = 16'd4096;
  localparam int unsigned CountWidth  = 17;
  localparam logic [CountWidth-1:0] SatCount = 17'h10000;

  // Characters of interest
  localparam logic [7:0] ChrNul       = 8'h00;
  localparam logic [7:0] ChrSlash     = 8'h2F;
  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrColon     = 8'h3A;
  localparam logic [7:0] ChrDot       = 8'h2E;

  // Allowed range of the next UTF-8 continuation byte
  typedef enum logic [2:0] {
    RngAny  = 3'd0,  // 80..BF
    RngA0Bf = 3'd1,  // after E0
    Rng809F = 3'd2,  // after ED
    Rng90Bf = 3'd3,  // after F0
    Rng808F = 3'd4   // after F4
  } cont_rng_e;

  // Dot tracking within one path segment
  typedef enum logic [1:0] {
    SegStart  = 2'd0,
    SegDot    = 2'd1,
    SegDotDot = 2'd2,
    SegOther  = 2'd3
  } seg_e;

  // Verdict codes
  typedef enum logic [2:0] {
    RsnOk       = 3'd0,
    RsnEmpty    = 3'd1,
    RsnTooLong  = 3'd2,
    RsnBadUtf8  = 3'd3,
    RsnAbsolute = 3'd4,
    RsnBadSep   = 3'd5,
    RsnDotDot   = 3'd6
  } reason_e;

  typedef struct packed {
    logic    ok;
    reason_e reason;
  } verdict_t;

endpackage

@@ src/pnv_scan.sv @@
`timescale 1ns / 1ps

// Per-name scan state: updated once per byte, verdict formed on the terminator
module pnv_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  input  logic [15:0]          max_len_i,
  output pnv_pkg::verdict_t    verdict_o
);

  logic [pnv_pkg::CountWidth-1:0] count_q, count_d;
  logic [1:0]                     left_q, left_d;
  pnv_pkg::cont_rng_e             rng_q, rng_d;
  logic                           err_q, err_d;
  logic                           slash_q, slash_d;
  logic                           sep_q, sep_d;
  pnv_pkg::seg_e                  seg_q, seg_d;
  logic                           dd_q, dd_d;

  logic in_rng;
  logic relead;
  logic term;

  assign term = (byte_i == pnv_pkg::ChrNul);

  // Continuation range check
  always_comb begin
    case (rng_q)
      pnv_pkg::RngA0Bf: in_rng = (byte_i >= 8'hA0) && (byte_i <= 8'hBF);
      pnv_pkg::Rng809F: in_rng = (byte_i >= 8'h80) && (byte_i <= 8'h9F);
      pnv_pkg::Rng90Bf: in_rng = (byte_i >= 8'h90) && (byte_i <= 8'hBF);
      pnv_pkg::Rng808F: in_rng = (byte_i >= 8'h80) && (byte_i <= 8'h8F);
      default:          in_rng = (byte_i >= 8'h80) && (byte_i <= 8'hBF);
    endcase
  end

  // Next state for a data byte or a terminator
  always_comb begin
    count_d = count_q;
    left_d  = left_q;
    rng_d   = rng_q;
    err_d   = err_q;
    slash_d = slash_q;
    sep_d   = sep_q;
    seg_d   = seg_q;
    dd_d    = dd_q;
    relead  = 1'b1;

    if (fire_i && term) begin
      count_d = '0;
      left_d  = '0;
      rng_d   = pnv_pkg::RngAny;
      err_d   = 1'b0;
      slash_d = 1'b0;
      sep_d   = 1'b0;
      seg_d   = pnv_pkg::SegStart;
      dd_d    = 1'b0;
    end else if (fire_i) begin
      if ((count_q == '0) && (byte_i == pnv_pkg::ChrSlash)) begin
        slash_d = 1'b1;
      end
      if (count_q != pnv_pkg::SatCount) begin
        count_d = count_q + 1'b1;
      end

      // UTF-8: pending continuation first; a misfit byte is rejudged as a lead
      if (left_q != 2'd0) begin
        rng_d = pnv_pkg::RngAny;
        if (in_rng) begin
          left_d = left_q - 2'd1;
          relead = 1'b0;
        end else begin
          err_d  = 1'b1;
          left_d = 2'd0;
        end
      end
      if (relead && byte_i[7]) begin
        priority if ((byte_i >= 8'hC2) && (byte_i <= 8'hDF)) begin
          left_d = 2'd1; rng_d = pnv_pkg::RngAny;
        end else if (byte_i == 8'hE0) begin
          left_d = 2'd2; rng_d = pnv_pkg::RngA0Bf;
        end else if (byte_i == 8'hED) begin
          left_d = 2'd2; rng_d = pnv_pkg::Rng809F;
        end else if ((byte_i >= 8'hE1) && (byte_i <= 8'hEF)) begin
          left_d = 2'd2; rng_d = pnv_pkg::RngAny;
        end else if (byte_i == 8'hF0) begin
          left_d = 2'd3; rng_d = pnv_pkg::Rng90Bf;
        end else if ((byte_i >= 8'hF1) && (byte_i <= 8'hF3)) begin
          left_d = 2'd3; rng_d = pnv_pkg::RngAny;
        end else if (byte_i == 8'hF4) begin
          left_d = 2'd3; rng_d = pnv_pkg::Rng808F;
        end else begin
          err_d = 1'b1;
        end
      end

      // Separator checks
      if ((byte_i == pnv_pkg::ChrBackslash) || (byte_i == pnv_pkg::ChrColon)) begin
        sep_d = 1'b1;
      end

      // Segment dot tracking
      priority if (byte_i == pnv_pkg::ChrSlash) begin
        if (seg_q == pnv_pkg::SegDotDot) begin
          dd_d = 1'b1;
        end
        seg_d = pnv_pkg::SegStart;
      end else if (byte_i == pnv_pkg::ChrDot) begin
        unique case (seg_q)
          pnv_pkg::SegStart:  seg_d = pnv_pkg::SegDot;
          pnv_pkg::SegDot:    seg_d = pnv_pkg::SegDotDot;
          pnv_pkg::SegDotDot: seg_d = pnv_pkg::SegOther;
          pnv_pkg::SegOther:  seg_d = pnv_pkg::SegOther;
          default:            seg_d = pnv_pkg::SegOther;
        endcase
      end else begin
        seg_d = pnv_pkg::SegOther;
      end
    end
  end

  // Verdict from the state as it stands at the terminator
  always_comb begin
    priority if (count_q == '0) begin
      verdict_o.reason = pnv_pkg::RsnEmpty;
    end else if (count_q > {1'b0, max_len_i}) begin
      verdict_o.reason = pnv_pkg::RsnTooLong;
    end else if (err_q || (left_q != 2'd0)) begin
      verdict_o.reason = pnv_pkg::RsnBadUtf8;
    end else if (slash_q) begin
      verdict_o.reason = pnv_pkg::RsnAbsolute;
    end else if (sep_q) begin
      verdict_o.reason = pnv_pkg::RsnBadSep;
    end else if (dd_q || (seg_q == pnv_pkg::SegDotDot)) begin
      verdict_o.reason = pnv_pkg::RsnDotDot;
    end else begin
      verdict_o.reason = pnv_pkg::RsnOk;
    end
    verdict_o.ok = (verdict_o.reason == pnv_pkg::RsnOk);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
      rng_q   <= pnv_pkg::RngAny;
      err_q   <= 1'b0;
      slash_q <= 1'b0;
      sep_q   <= 1'b0;
      seg_q   <= pnv_pkg::SegStart;
      dd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
      rng_q   <= rng_d;
      err_q   <= err_d;
      slash_q <= slash_d;
      sep_q   <= sep_d;
      seg_q   <= seg_d;
      dd_q    <= dd_d;
    end
  end

endmodule

@@ src/pnv_out.sv @@
`timescale 1ns / 1ps

// Result register: holds one verdict until the sink takes it
module pnv_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  pnv_pkg::verdict_t verdict_i,
  input  logic              out_stall_i,
  output logic              free_o,
  output logic              out_valid_o,
  output logic              name_ok_o,
  output logic [2:0]        reject_reason_o
);

  logic              valid_q, valid_d;
  pnv_pkg::verdict_t res_q;

  // Free when empty or being drained this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= verdict_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign name_ok_o       = res_q.ok;
  assign reject_reason_o = res_q.reason;

endmodule

@@ src/package_part_name_validator_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                          Transfer
// in        sink       in_valid_i, in_stall_o,          valid && !stall
//                      name_byte_i
// out       source     out_valid_o, out_stall_i,        valid && !stall
//                      name_ok_o, reject_reason_o
// cfg       sink       cfg_we_i, cfg_wdata_i            we (max_name_length)
//
// One byte per cycle. A byte is registered at the input, then updates the scan
// state in the next cycle; a zero byte loads its verdict into the result
// register, and out_valid_o rises once that load has happened.
// Reset clears the scan state, empties both registers and sets the limit to 4096.
// A stalled result holds only terminators back: data bytes keep flowing.
module package_part_name_validator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  name_byte_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        name_ok_o,
  output logic [2:0]  reject_reason_o
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        byte_q;
  logic [15:0]       max_len_q;
  logic              out_free;
  logic              fire;
  logic              in_take;
  pnv_pkg::verdict_t verdict;

  // Held byte moves on unless it is a terminator facing a full result register
  assign fire       = in_valid_q && ((byte_q != pnv_pkg::ChrNul) || out_free);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      max_len_q  <= pnv_pkg::MaxLenReset;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // Input byte register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= name_byte_i;
    end
  end

  pnv_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (byte_q),
    .max_len_i (max_len_q),
    .verdict_o (verdict)
  );

  pnv_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (fire && (byte_q == pnv_pkg::ChrNul)),
    .verdict_i       (verdict),
    .out_stall_i     (out_stall_i),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .name_ok_o       (name_ok_o),
    .reject_reason_o (reject_reason_o)
  );

endmodule

@@ tb/pnv_verdict_pkg.sv @@
`timescale 1ns / 1ps

package pnv_verdict_pkg;

  import pnv_pkg::*;

  // Tracks the scan state of the name in flight and holds the verdicts still owed
  class name_verdict_checker;
    logic [15:0]           max_len;
    logic [CountWidth-1:0] byte_cnt;
    logic [1:0]            cont_left;
    cont_rng_e             cont_rng;
    bit                    utf8_bad;
    bit                    lead_slash;
    bit                    sep_bad;
    bit                    dotdot;
    seg_e                  seg;
    verdict_t              owed_verdicts[$];
    int unsigned           errors;

    function new();
      max_len = MaxLenReset;
      errors  = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      byte_cnt   = '0;
      cont_left  = 2'd0;
      cont_rng   = RngAny;
      utf8_bad   = 1'b0;
      lead_slash = 1'b0;
      sep_bad    = 1'b0;
      dotdot     = 1'b0;
      seg        = SegStart;
    endfunction

    function void set_limit(logic [15:0] value);
      max_len = value;
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction

    function bit cont_in_range(logic [7:0] b);
      case (cont_rng)
        RngA0Bf: return b >= 8'hA0 && b <= 8'hBF;
        Rng809F: return b >= 8'h80 && b <= 8'h9F;
        Rng90Bf: return b >= 8'h90 && b <= 8'hBF;
        Rng808F: return b >= 8'h80 && b <= 8'h8F;
        default: return b >= 8'h80 && b <= 8'hBF;
      endcase
    endfunction

    // Strict UTF-8 decoder step; a rejected continuation is judged again as a lead
    function void scan_utf8(logic [7:0] b);
      if (cont_left != 2'd0) begin
        if (cont_in_range(b)) begin
          cont_left = cont_left - 2'd1;
          cont_rng  = RngAny;
          return;
        end
        utf8_bad  = 1'b1;
        cont_left = 2'd0;
        cont_rng  = RngAny;
      end
      if (b < 8'h80) return;
      if (b >= 8'hC2 && b <= 8'hDF) begin
        cont_left = 2'd1;
        cont_rng  = RngAny;
      end else if (b == 8'hE0) begin
        cont_left = 2'd2;
        cont_rng  = RngA0Bf;
      end else if (b == 8'hED) begin
        cont_left = 2'd2;
        cont_rng  = Rng809F;
      end else if (b >= 8'hE1 && b <= 8'hEF) begin
        cont_left = 2'd2;
        cont_rng  = RngAny;
      end else if (b == 8'hF0) begin
        cont_left = 2'd3;
        cont_rng  = Rng90Bf;
      end else if (b >= 8'hF1 && b <= 8'hF3) begin
        cont_left = 2'd3;
        cont_rng  = RngAny;
      end else if (b == 8'hF4) begin
        cont_left = 2'd3;
        cont_rng  = Rng808F;
      end else begin
        // stray continuation, C0/C1, F5..FF
        utf8_bad = 1'b1;
      end
    endfunction

    // Called for every accepted input transaction
    function void note_byte(logic [7:0] b);
      reason_e  rsn;
      verdict_t want;
      if (b != ChrNul) begin
        if (byte_cnt == '0 && b == ChrSlash) lead_slash = 1'b1;
        if (byte_cnt < SatCount) byte_cnt = byte_cnt + 1'b1;
        scan_utf8(b);
        if (b == ChrBackslash || b == ChrColon) sep_bad = 1'b1;
        if (b == ChrSlash) begin
          if (seg == SegDotDot) dotdot = 1'b1;
          seg = SegStart;
        end else if (b == ChrDot) begin
          case (seg)
            SegStart: seg = SegDot;
            SegDot:   seg = SegDotDot;
            default:  seg = SegOther;
          endcase
        end else begin
          seg = SegOther;
        end
        return;
      end
      // terminator: first failing check wins
      if (seg == SegDotDot) dotdot = 1'b1;
      if (byte_cnt == '0) rsn = RsnEmpty;
      else if (byte_cnt > {1'b0, max_len}) rsn = RsnTooLong;
      else if (utf8_bad || cont_left != 2'd0) rsn = RsnBadUtf8;
      else if (lead_slash) rsn = RsnAbsolute;
      else if (sep_bad) rsn = RsnBadSep;
      else if (dotdot) rsn = RsnDotDot;
      else rsn = RsnOk;
      want.ok     = (rsn == RsnOk);
      want.reason = rsn;
      owed_verdicts.push_back(want);
      clear_scan();
    endfunction

    // Called for every accepted output transaction
    function void check_verdict(logic ok, logic [2:0] rsn);
      verdict_t want;
      if (owed_verdicts.size() == 0) begin
        $display("%0t: verdict with none owed, actual ok=%0b reason=%0d", $time, ok, rsn);
        errors++;
        return;
      end
      want = owed_verdicts.pop_front();
      if (ok !== want.ok) begin
        $display("%0t: name_ok expected %0b actual %0b", $time, want.ok, ok);
        errors++;
      end
      if (rsn !== want.reason) begin
        $display("%0t: reject_reason expected %0d actual %0d", $time, want.reason, rsn);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/package_part_name_validator_core_test.sv @@
`timescale 1ns / 1ps

module package_part_name_validator_core_test;

  import pnv_pkg::*;
  import pnv_verdict_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  name_byte_i = 8'h00;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        name_ok_o;
  logic [2:0]  reject_reason_o;

  name_verdict_checker sb;
  logic [7:0]  name_buf[$];
  bit          quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;

  package_part_name_validator_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .name_byte_i    (name_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .name_ok_o      (name_ok_o),
    .reject_reason_o(reject_reason_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall after each transaction, values sampled before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_verdict(name_ok_o, reject_reason_o);
        stall_left = quiet ? 0 : $urandom_range(0, 3);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  function automatic logic [7:0] rand_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    name_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
  endtask

  task automatic send_name();
    foreach (name_buf[i]) send_byte(name_buf[i]);
    send_byte(ChrNul);
  endtask

  task automatic send_text(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    send_name();
  endtask

  // Hold off until every owed verdict is back and the pipe is empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(value);
  endtask

  // One UTF-8 sequence, well-formed or damaged
  function automatic void add_utf8(bit broken);
    logic [7:0] seq[$];
    logic [7:0] lead;
    case ($urandom_range(2, 4))
      2: seq = {rand_byte('hC2, 'hDF), rand_byte('h80, 'hBF)};
      3: begin
        lead = rand_byte('hE0, 'hEF);
        seq = {lead, (lead == 8'hE0) ? rand_byte('hA0, 'hBF) :
                     (lead == 8'hED) ? rand_byte('h80, 'h9F) : rand_byte('h80, 'hBF),
               rand_byte('h80, 'hBF)};
      end
      default: begin
        lead = rand_byte('hF0, 'hF4);
        seq = {lead, (lead == 8'hF0) ? rand_byte('h90, 'hBF) :
                     (lead == 8'hF4) ? rand_byte('h80, 'h8F) : rand_byte('h80, 'hBF),
               rand_byte('h80, 'hBF), rand_byte('h80, 'hBF)};
      end
    endcase
    if (broken) begin
      case ($urandom_range(0, 3))
        0: void'(seq.pop_back());
        1: seq[1] = rand_byte('h01, 'hFF);
        2: seq = {rand_byte('h80, 'hBF)};
        default: seq = {$urandom_range(0, 1) ? rand_byte('hC0, 'hC1) : rand_byte('hF5, 'hFF)};
      endcase
    end
    foreach (seq[i]) name_buf.push_back(seq[i]);
  endfunction

  // Mostly plausible part names, some with damage
  function automatic void make_name();
    int unsigned ntok;
    name_buf.delete();
    if ($urandom_range(0, 9) == 0) name_buf.push_back(ChrSlash);
    ntok = $urandom_range(0, 8);
    repeat (ntok) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: name_buf.push_back(rand_byte("a", "z"));
        8: name_buf.push_back(rand_byte('h01, 'h7F));
        9, 10: name_buf.push_back(ChrSlash);
        11, 12: name_buf.push_back(ChrDot);
        13: name_buf = {name_buf, ChrSlash, ChrDot, ChrDot};
        14: name_buf.push_back($urandom_range(0, 2) == 0 ?
                               ($urandom_range(0, 1) ? ChrBackslash : ChrColon) :
                               rand_byte("0", "9"));
        15, 16, 17, 18: add_utf8(1'b0);
        default: begin
          if ($urandom_range(0, 2) == 0) add_utf8(1'b1);
          else name_buf.push_back(rand_byte('h01, 'hFF));
        end
      endcase
    end
  endfunction

  initial begin
    int unsigned rand_bytes;
    logic [15:0] lim;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed names at the reset limit
    name_buf.delete();
    send_name();
    send_text("a");
    send_text("/a");
    send_text("a\\b");
    send_text("a:b");
    send_text("a/../b");
    send_text("x/..");
    send_text(".../.a");
    send_text("/a:b");
    name_buf = {8'hC3, 8'hA9, 8'h7F, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF};
    send_name();
    name_buf = {8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_name();
    name_buf = {8'hE0, 8'h9F, 8'h80};
    send_name();
    name_buf = {8'hED, 8'hA0, 8'h80};
    send_name();
    name_buf = {8'hF4, 8'h90, 8'h80, 8'h80};
    send_name();
    name_buf = {8'hC0, 8'hAF};
    send_name();
    name_buf = {8'hFF, ChrBackslash};
    send_name();
    name_buf = {"a", 8'hC3};
    send_name();

    // Zero limit, then a limit of one byte
    write_limit(16'h0000);
    send_text("a");
    name_buf.delete();
    send_name();
    write_limit(16'h0001);
    send_text("b");
    send_text("bc");

    // Largest limit
    write_limit(16'hFFFF);
    send_text("c/d.e");

    // Random names over several limits
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: lim = 16'($urandom_range(2, 16));
        1: lim = 16'($urandom);
        2: lim = MaxLenReset;
        default: lim = 16'($urandom_range(4, 12));
      endcase
      write_limit(lim);
      rand_bytes = 0;
      while (rand_bytes < 125) begin
        quiet = ($urandom_range(0, 4) == 0);
        make_name();
        rand_bytes += name_buf.size() + 1;
        send_name();
        if (phase == 1 && $urandom_range(0, 15) == 0) wait_drained();
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
